// ===== rtl/dshot_pkg.sv =====
// Shared types, constants and the frame builder for the DShot frame pulse encoder.
// Used by every module in rtl/; depends on nothing.

package dshot_pkg;

  localparam int TICK_W  = 10;
  localparam int FRAME_W = 16;
  localparam int CFG_IDX_W = 2;

  // Operation codes of an input item.
  localparam logic OP_SPEED   = 1'b0;
  localparam logic OP_COMMAND = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_SHORT_TICKS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_TICKS  = 2'd1;

  localparam logic [TICK_W-1:0] SHORT_TICKS_RST = 10'd44;
  localparam logic [TICK_W-1:0] LONG_TICKS_RST  = 10'd89;

  // Throttle mapping constants.
  localparam logic [15:0] POS_BASE  = 16'd47;
  localparam logic [15:0] POS_LIMIT = 16'd1000;
  localparam logic [10:0] POS_TOP   = 11'd1047;
  localparam logic [15:0] NEG_BASE  = 16'd1048;
  localparam logic [15:0] NEG_LIMIT = 16'd999;
  localparam logic [10:0] NEG_TOP   = 11'd2047;

  typedef struct packed {
    logic               operation;
    logic signed [15:0] speed;
    logic [10:0]        command_code;
  } item_t;

  typedef struct packed {
    logic [TICK_W-1:0] high_ticks;
    logic [TICK_W-1:0] low_ticks;
    logic              bit_value;
    logic              last_pulse;
  } pulse_t;

  typedef struct packed {
    logic               valid;
    logic [FRAME_W-1:0] frame;
  } push_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  // Builds the 16-bit frame: 11-bit value, telemetry bit, 4-bit checksum.
  function automatic logic [FRAME_W-1:0] build_frame(item_t it);
    logic [15:0] bits;
    logic [15:0] mag;
    logic [10:0] thr;
    logic [11:0] top;
    logic [3:0]  sum;
    bits = it.speed;
    mag  = 16'd0 - bits;
    if (bits == 16'd0) begin
      thr = 11'd0;
    end else if (!bits[15]) begin
      thr = (bits >= POS_LIMIT) ? POS_TOP : 11'(bits + POS_BASE);
    end else begin
      thr = (mag >= NEG_LIMIT) ? NEG_TOP : 11'(mag + NEG_BASE);
    end
    if (it.operation == OP_COMMAND) begin
      top = {it.command_code, 1'b1};
    end else begin
      top = {thr, 1'b0};
    end
    sum = top[11:8] ^ top[7:4] ^ top[3:0];
    return {top, sum};
  endfunction

endpackage

// ===== rtl/dshot_front.sv =====
// Front stage: accepts input beats and registers the finished 16-bit frame.
// Depends on dshot_pkg for the item type and the frame builder.

module dshot_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_stall,
  input  dshot_pkg::item_t    item,
  input  dshot_pkg::q_status_t q_status,
  output dshot_pkg::push_t    push
);

  logic                          held;
  logic [dshot_pkg::FRAME_W-1:0] frame;

  // The held frame leaves whenever the queue has room, so a new beat can
  // land in the same cycle.
  assign item_stall = held && q_status.full;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (!item_stall) begin
      held <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!item_stall && item_valid) begin
      frame <= dshot_pkg::build_frame(item);
    end
  end

  assign push.valid = held && !q_status.full;
  assign push.frame = frame;

endmodule

// ===== rtl/dshot_queue.sv =====
// Short frame queue between the front stage and the pulse serializer.
// Depends on dshot_pkg for the push and status types.

module dshot_queue #(
  parameter int DEPTH = 2
) (
  input  logic                          clk,
  input  logic                          rst,
  input  dshot_pkg::push_t              push,
  input  logic                          pop,
  output logic [dshot_pkg::FRAME_W-1:0] head,
  output dshot_pkg::q_status_t          q_status
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [dshot_pkg::FRAME_W-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  function automatic logic [PTR_W-1:0] bump(logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (push.valid) begin
      mem[wr_ptr] <= push.frame;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push.valid) begin
        wr_ptr <= bump(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= bump(rd_ptr);
      end
      if (push.valid && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push.valid) begin
        count <= count - 1'b1;
      end
    end
  end

  assign head           = mem[rd_ptr];
  assign q_status.full  = (count == CNT_W'(DEPTH));
  assign q_status.empty = (count == '0);

endmodule

// ===== rtl/dshot_back.sv =====
// Back stage: shifts each queued frame out MSB first as sixteen pulse beats.
// Depends on dshot_pkg for the pulse and status types.

module dshot_back (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [dshot_pkg::TICK_W-1:0]  short_ticks,
  input  logic [dshot_pkg::TICK_W-1:0]  long_ticks,
  input  logic [dshot_pkg::FRAME_W-1:0] head,
  input  dshot_pkg::q_status_t          q_status,
  output logic                          pop,
  output logic                          pulse_valid,
  input  logic                          pulse_stall,
  output dshot_pkg::pulse_t             pulse
);

  logic                          busy;
  logic [dshot_pkg::FRAME_W-1:0] shreg;
  logic [3:0]                    cnt;
  logic                          advance;
  logic                          emit;
  logic                          emit_bit;
  logic                          emit_last;

  assign advance = !pulse_valid || !pulse_stall;
  assign pop     = advance && !busy && !q_status.empty;
  assign emit    = advance && (busy || !q_status.empty);

  // A fresh frame sends its top bit straight from the queue head.
  assign emit_bit  = busy ? shreg[dshot_pkg::FRAME_W-1] : head[dshot_pkg::FRAME_W-1];
  assign emit_last = busy && (cnt == 4'd15);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy        <= 1'b0;
      cnt         <= 4'd0;
      pulse_valid <= 1'b0;
    end else if (advance) begin
      pulse_valid <= emit;
      if (busy) begin
        cnt <= cnt + 4'd1;
        if (cnt == 4'd15) begin
          busy <= 1'b0;
        end
      end else if (pop) begin
        busy <= 1'b1;
        cnt  <= 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      if (busy) begin
        shreg <= {shreg[dshot_pkg::FRAME_W-2:0], 1'b0};
      end else begin
        shreg <= {head[dshot_pkg::FRAME_W-2:0], 1'b0};
      end
    end
    if (emit) begin
      pulse.high_ticks <= emit_bit ? long_ticks : short_ticks;
      pulse.low_ticks  <= emit_bit ? short_ticks : long_ticks;
      pulse.bit_value  <= emit_bit;
      pulse.last_pulse <= emit_last;
    end
  end

endmodule

// ===== rtl/dshot_frame_pulse_encoder.sv =====
// DShot frame pulse encoder, top level.
// Each input beat carries either a signed speed (operation 0) or a raw 11-bit
// command (operation 1). The block builds the 16-bit frame (value, telemetry
// bit, XOR checksum) and sends it MSB first as sixteen pulse beats, each with
// a high time, a low time, the bit and a flag on the sixteenth pulse.
// Channels use valid/stall; a beat moves on an edge with valid high and stall
// low. Pulse tick lengths come from two registers written through the cfg
// port (index 0 short phase, index 1 long phase); write them only while idle.
// The first pulse of a frame passes the front register, the frame queue and
// the pulse register. The pulse serializer emits one bit per cycle while the
// receiver does not stall; a frame queue and the front register
// let up to QUEUE_DEPTH + 1 frames wait while the serializer is busy.
// When the receiver stalls, the pulse register holds and the serializer
// waits; the input side stalls only once the queue and front register fill.
// Synchronous reset empties all stages and restores ticks to 44 and 89.
// Depends on dshot_pkg, dshot_front, dshot_queue and dshot_back.

module dshot_frame_pulse_encoder #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              item_valid,
  output logic                              item_stall,
  input  dshot_pkg::item_t                  item,
  output logic                              pulse_valid,
  input  logic                              pulse_stall,
  output dshot_pkg::pulse_t                 pulse,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [dshot_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [dshot_pkg::TICK_W-1:0]      cfg_data
);

  logic [dshot_pkg::TICK_W-1:0]  short_ticks;
  logic [dshot_pkg::TICK_W-1:0]  long_ticks;
  dshot_pkg::push_t              push;
  dshot_pkg::q_status_t          q_status;
  logic [dshot_pkg::FRAME_W-1:0] head;
  logic                          pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      short_ticks <= dshot_pkg::SHORT_TICKS_RST;
      long_ticks  <= dshot_pkg::LONG_TICKS_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        dshot_pkg::CFG_SHORT_TICKS: short_ticks <= cfg_data;
        dshot_pkg::CFG_LONG_TICKS:  long_ticks  <= cfg_data;
        default: ;
      endcase
    end
  end

  dshot_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item       (item),
    .q_status   (q_status),
    .push       (push)
  );

  dshot_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .pop      (pop),
    .head     (head),
    .q_status (q_status)
  );

  dshot_back u_back (
    .clk         (clk),
    .rst         (rst),
    .short_ticks (short_ticks),
    .long_ticks  (long_ticks),
    .head        (head),
    .q_status    (q_status),
    .pop         (pop),
    .pulse_valid (pulse_valid),
    .pulse_stall (pulse_stall),
    .pulse       (pulse)
  );

endmodule
